### design/lfu_pkg.sv
// shared types and constants for the lfu cache table
package lfu_pkg;
    localparam int KeyW = 32;
    localparam int DataW = 32;
    localparam int CntW = 32;
    localparam int CapW = 5;
    localparam int InW = 72;
    localparam int OutW = 72;
    localparam logic [CapW-1:0] CapReset = 5'd16;
    localparam logic [CntW-1:0] CntMax = '1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_HIT   = 7'b0000100,
        ST_EVICT = 7'b0001000,
        ST_FREE  = 7'b0010000,
        ST_FILL  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic start;     // latch request, reset scan
        logic scan;      // examine one entry
        logic do_hit;    // update hit entry
        logic do_evict;  // drop victim
        logic do_fill;   // write new entry
        logic clear_out; // result with all zero fields
        logic out_load;  // present result
        logic out_take;  // result taken
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic is_put;
        logic cap_zero;
        logic full;
        logic has_victim;
        logic has_free;
        logic out_busy;
    } status_t;
endpackage

### design/lfu_datapath.sv
// entry storage, scan logic and result register
module lfu_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lfu_pkg::cmd_t         cmd,
    output lfu_pkg::status_t      status,
    input  logic                  cfg_we,
    input  logic [lfu_pkg::CapW-1:0] cfg_wdata,
    input  logic [lfu_pkg::InW-1:0]  in_data,
    output logic [lfu_pkg::OutW-1:0] out_data
);
    localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RankW = IdxW;
    localparam int FillW = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0] valid_reg;
    logic [lfu_pkg::KeyW-1:0] key_mem [ENTRIES];
    logic [lfu_pkg::DataW-1:0] data_mem [ENTRIES];
    logic [lfu_pkg::CntW-1:0] cnt_mem [ENTRIES];
    logic [RankW-1:0] rank_reg [ENTRIES];
    logic [FillW-1:0] fill_reg;
    logic [lfu_pkg::CapW-1:0] cap_reg;

    logic kind_reg;
    logic [lfu_pkg::KeyW-1:0] key_reg;
    logic [lfu_pkg::DataW-1:0] val_reg;
    logic [FillW-1:0] scan_reg;
    logic found_reg, vic_ok_reg, free_ok_reg;
    logic [IdxW-1:0] hit_idx_reg, vic_idx_reg, free_idx_reg;
    logic [lfu_pkg::CntW-1:0] vic_cnt_reg;
    logic [RankW-1:0] vic_rank_reg;
    logic evicted_reg;
    logic [lfu_pkg::KeyW-1:0] ev_key_reg;
    logic out_busy_reg;
    logic [lfu_pkg::OutW-1:0] out_reg;

    logic [IdxW-1:0] si;
    logic [lfu_pkg::CapW-1:0] cap_eff;
    logic [lfu_pkg::CntW-1:0] hit_cnt;
    logic [RankW-1:0] hit_rank;

    assign si = scan_reg[IdxW-1:0];
    assign cap_eff = (int'(cap_reg) > ENTRIES) ? lfu_pkg::CapW'(ENTRIES) : cap_reg;
    assign hit_cnt = cnt_mem[hit_idx_reg];
    assign hit_rank = rank_reg[hit_idx_reg];

    assign status.scan_done = (scan_reg == FillW'(ENTRIES));
    assign status.found = found_reg;
    assign status.is_put = kind_reg;
    assign status.cap_zero = (cap_eff == '0);
    assign status.full = (int'(fill_reg) >= int'(cap_eff));
    assign status.has_victim = vic_ok_reg;
    assign status.has_free = free_ok_reg;
    assign status.out_busy = out_busy_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lfu_pkg::CapReset;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg <= '0;
            out_busy_reg <= 1'b0;
            scan_reg <= '0;
        end
        else
        begin
            if (cmd.out_take)
            begin
                out_busy_reg <= 1'b0;
            end
            if (cmd.out_load)
            begin
                out_busy_reg <= 1'b1;
            end
            if (cmd.start)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.do_evict)
            begin
                valid_reg[vic_idx_reg] <= 1'b0;
                fill_reg <= fill_reg - 1'b1;
            end
            if (cmd.do_fill)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg <= in_data[0];
            key_reg <= in_data[32:1];
            val_reg <= in_data[64:33];
            found_reg <= 1'b0;
            vic_ok_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            evicted_reg <= 1'b0;
            ev_key_reg <= '0;
        end
        else if (cmd.scan)
        begin
            if (valid_reg[si])
            begin
                if (!found_reg && key_mem[si] == key_reg)
                begin
                    found_reg <= 1'b1;
                    hit_idx_reg <= si;
                end
                if (!vic_ok_reg || cnt_mem[si] < vic_cnt_reg ||
                    (cnt_mem[si] == vic_cnt_reg && rank_reg[si] > vic_rank_reg))
                begin
                    vic_ok_reg <= 1'b1;
                    vic_idx_reg <= si;
                    vic_cnt_reg <= cnt_mem[si];
                    vic_rank_reg <= rank_reg[si];
                end
            end
            else if (!free_ok_reg)
            begin
                free_ok_reg <= 1'b1;
                free_idx_reg <= si;
            end
        end
        if (cmd.do_hit)
        begin
            if (hit_cnt != lfu_pkg::CntMax)
            begin
                cnt_mem[hit_idx_reg] <= hit_cnt + 1'b1;
            end
            if (kind_reg)
            begin
                data_mem[hit_idx_reg] <= val_reg;
            end
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && IdxW'(i) != hit_idx_reg && rank_reg[i] < hit_rank)
                begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
            rank_reg[hit_idx_reg] <= '0;
        end
        if (cmd.do_evict)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && rank_reg[i] > vic_rank_reg)
                begin
                    rank_reg[i] <= rank_reg[i] - 1'b1;
                end
            end
            evicted_reg <= 1'b1;
            ev_key_reg <= key_mem[vic_idx_reg];
            free_idx_reg <= vic_idx_reg;
            free_ok_reg <= 1'b1;
        end
        if (cmd.do_fill)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i])
                begin
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
            key_mem[free_idx_reg] <= key_reg;
            data_mem[free_idx_reg] <= val_reg;
            cnt_mem[free_idx_reg] <= lfu_pkg::CntW'(1);
            rank_reg[free_idx_reg] <= '0;
        end
        if (cmd.out_load)
        begin
            if (cmd.clear_out)
            begin
                out_reg <= '0;
            end
            else
            begin
                out_reg <= {6'd0, ev_key_reg, evicted_reg,
                            (found_reg && !kind_reg) ? data_mem[hit_idx_reg] : 32'd0,
                            found_reg};
            end
        end
    end
endmodule

### design/lfu_ctrl.sv
// sequencing state machine for one cache request
module lfu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             out_fire,
    input  lfu_pkg::status_t status,
    output lfu_pkg::cmd_t    cmd,
    output logic             in_ready
);
    lfu_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == lfu_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.out_take = out_fire;
        unique case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.start = 1'b1;
                    state_next = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    priority if (status.cap_zero)
                        state_next = lfu_pkg::ST_OUT;
                    else if (status.found)
                        state_next = lfu_pkg::ST_HIT;
                    else if (!status.is_put)
                        state_next = lfu_pkg::ST_OUT;
                    else if (status.full && status.has_victim)
                        state_next = lfu_pkg::ST_EVICT;
                    else
                        state_next = lfu_pkg::ST_FREE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            lfu_pkg::ST_HIT:
            begin
                cmd.do_hit = 1'b1;
                state_next = lfu_pkg::ST_OUT;
            end
            lfu_pkg::ST_EVICT:
            begin
                cmd.do_evict = 1'b1;
                state_next = lfu_pkg::ST_FILL;
            end
            lfu_pkg::ST_FREE:
            begin
                state_next = status.has_free ? lfu_pkg::ST_FILL : lfu_pkg::ST_OUT;
            end
            lfu_pkg::ST_FILL:
            begin
                cmd.do_fill = 1'b1;
                state_next = lfu_pkg::ST_OUT;
            end
            lfu_pkg::ST_OUT:
            begin
                if (!status.out_busy || out_fire)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clear_out = status.cap_zero;
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

### design/lfu_cache_table.sv
// top level of the lfu cache table
// One request at a time: a scan of one entry per cycle finds the key match and the
// victim, then up to two update steps run and the result register is loaded once an
// older result is taken. The result register holds a finished result while the next
// request is accepted. Reset clears the valid bits, fill count, scan index and result
// flag but not the entry contents; there is no clearing pass.
module lfu_cache_table #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // kind, key, value, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata   // hit, read_value, evicted, evicted_key, zero fill
);
    lfu_pkg::cmd_t cmd;
    lfu_pkg::status_t status;
    logic in_fire, out_fire;

    assign in_fire = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign m_tvalid = status.out_busy;

    lfu_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .status(status), .cmd(cmd), .in_ready(s_tready)
    );

    lfu_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .in_data(s_tdata), .out_data(m_tdata)
    );
endmodule

### design/lfu_checker.sv
// port checker for the lfu cache table
module lfu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[71:66] == 6'd0)
        else $error("result padding not zero");
    a_getev: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[33])
        else $error("hit with eviction");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");
endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### bench/lfu_cache_table_tb.sv
// self-checking testbench for the lfu cache table
`timescale 1ns / 1ps

module lfu_cache_table_tb;
    localparam int Slots = 16;
    localparam logic KindGet = 1'b0;
    localparam logic KindPut = 1'b1;
    localparam int IdleLimit = 20000;

    typedef struct packed {
        logic hit;
        logic [31:0] read_value;
        logic evicted;
        logic [31:0] evicted_key;
    } lookup_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [4:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [71:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [71:0] m_tdata;

    // cache shadow
    logic [4:0] shadow_cap;
    logic shadow_valid [Slots];
    logic [31:0] shadow_key [Slots];
    logic [31:0] shadow_data [Slots];
    logic [31:0] shadow_uses [Slots];
    logic [3:0] shadow_rank [Slots];
    int shadow_fill;

    lookup_t pending_lookups [$];
    int mismatch_count;
    int idle_cycles;
    logic m_stall_on;
    logic [31:0] key_pool [8];

    lfu_cache_table i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic lookup_t predict_lookup(logic kind, logic [31:0] key, logic [31:0] value);
        lookup_t res;
        int cap;
        int found;
        int slot;
        int victim;
        logic [3:0] old_rank;
        res = '0;
        cap = (shadow_cap > Slots) ? Slots : shadow_cap;
        found = -1;
        slot = -1;
        if (cap == 0)
            return res;
        for (int i = 0; i < Slots; i++)
        begin
            if (found < 0 && shadow_valid[i] && shadow_key[i] == key)
                found = i;
        end
        if (found >= 0)
        begin
            res.hit = 1'b1;
            if (shadow_uses[found] != 32'hFFFF_FFFF)
                shadow_uses[found]++;
            old_rank = shadow_rank[found];
            for (int i = 0; i < Slots; i++)
            begin
                if (shadow_valid[i] && i != found && shadow_rank[i] < old_rank)
                    shadow_rank[i]++;
            end
            shadow_rank[found] = 0;
            if (kind == KindGet)
                res.read_value = shadow_data[found];
            else
                shadow_data[found] = value;
            return res;
        end
        if (kind == KindGet)
            return res;
        if (shadow_fill >= cap)
        begin
            victim = -1;
            for (int i = 0; i < Slots; i++)
            begin
                if (shadow_valid[i] && (victim < 0 || shadow_uses[i] < shadow_uses[victim]
                    || (shadow_uses[i] == shadow_uses[victim]
                        && shadow_rank[i] > shadow_rank[victim])))
                    victim = i;
            end
            if (victim >= 0)
            begin
                old_rank = shadow_rank[victim];
                shadow_valid[victim] = 1'b0;
                for (int i = 0; i < Slots; i++)
                begin
                    if (shadow_valid[i] && shadow_rank[i] > old_rank)
                        shadow_rank[i]--;
                end
                shadow_fill--;
                res.evicted = 1'b1;
                res.evicted_key = shadow_key[victim];
                slot = victim;
            end
        end
        if (slot < 0)
        begin
            for (int i = Slots - 1; i >= 0; i--)
            begin
                if (!shadow_valid[i])
                    slot = i;
            end
        end
        if (slot < 0)
            return res;
        for (int i = 0; i < Slots; i++)
        begin
            if (shadow_valid[i])
                shadow_rank[i]++;
        end
        shadow_valid[slot] = 1'b1;
        shadow_key[slot] = key;
        shadow_data[slot] = value;
        shadow_uses[slot] = 1;
        shadow_rank[slot] = 0;
        shadow_fill++;
        return res;
    endfunction

    task automatic send_request(logic kind, logic [31:0] key, logic [31:0] value);
        int gap;
        gap = gap_length();
        // step off the falling edge where valid was dropped
        repeat (gap + 1) @(negedge clk);
        s_tdata <= {7'd0, value, key, kind};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_lookups.push_back(predict_lookup(kind, key, value));
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(logic [4:0] cap);
        wait_drained();
        cfg_wdata <= cap;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_cap = cap;
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, 7)] + $urandom_range(0, 23);
        return $urandom();
    endfunction

    task automatic test_field_extremes();
        write_capacity(5'd16);
        send_request(KindGet, 32'h0, 32'h0);
        send_request(KindPut, 32'h0, 32'hFFFF_FFFF);
        send_request(KindPut, 32'hFFFF_FFFF, 32'h0);
        send_request(KindGet, 32'h0, 32'h1234_5678);
        send_request(KindGet, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KindPut, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_request(KindGet, 32'hFFFF_FFFF, 32'h0);
    endtask

    // fill past a small capacity so the lowest use count picks the victim
    task automatic test_eviction_order();
        write_capacity(5'd2);
        send_request(KindPut, 32'd100, 32'd1);
        send_request(KindPut, 32'd101, 32'd2);
        send_request(KindGet, 32'd100, 32'd0);
        send_request(KindPut, 32'd102, 32'd3);
        send_request(KindPut, 32'd103, 32'd4);
        send_request(KindGet, 32'd101, 32'd0);
        // lowering below the fill evicts one per new key
        write_capacity(5'd1);
        send_request(KindPut, 32'd104, 32'd5);
        send_request(KindPut, 32'd104, 32'd6);
        send_request(KindGet, 32'd104, 32'd0);
    endtask

    task automatic test_disabled_cache();
        write_capacity(5'd0);
        send_request(KindGet, 32'd104, 32'd0);
        send_request(KindPut, 32'd200, 32'd7);
        send_request(KindGet, 32'd200, 32'd0);
        // above the table size saturates
        write_capacity(5'd31);
        send_request(KindGet, 32'd104, 32'd0);
        send_request(KindPut, 32'd201, 32'd8);
    endtask

    task automatic test_random_traffic();
        logic [4:0] caps [6] = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd9};
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_capacity(caps[phase]);
            for (int n = 0; n < 330; n++)
                send_request(logic'($urandom_range(0, 1)), pick_key(), $urandom());
        end
    endtask

    always @(negedge clk)
    begin
        if (m_stall_on)
            m_tready <= ($urandom_range(0, 3) != 0);
        else
            m_tready <= 1'b1;
    end

    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            m_stall_on <= ~m_stall_on;
    end

    always @(posedge clk)
    begin
        lookup_t got;
        lookup_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[0], m_tdata[32:1], m_tdata[33], m_tdata[65:34]};
            if (pending_lookups.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (got.hit !== want.hit || got.read_value !== want.read_value
                    || got.evicted !== want.evicted || got.evicted_key !== want.evicted_key)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected hit=%b rd=%h ev=%b evk=%h",
                            want.hit, want.read_value, want.evicted, want.evicted_key);
                        $display("          got      hit=%b rd=%h ev=%b evk=%h",
                            got.hit, got.read_value, got.evicted, got.evicted_key);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        m_stall_on = 1'b0;
        mismatch_count = 0;
        idle_cycles = 0;
        shadow_cap = lfu_pkg::CapReset;
        shadow_fill = 0;
        for (int i = 0; i < Slots; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_data[i] = '0;
            shadow_uses[i] = '0;
            shadow_rank[i] = '0;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_field_extremes();
        test_eviction_order();
        test_disabled_cache();
        test_random_traffic();
        wait_drained();
        if (mismatch_count == 0 && pending_lookups.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

### files.f
design/lfu_pkg.sv
design/lfu_datapath.sv
design/lfu_ctrl.sv
design/lfu_cache_table.sv
design/lfu_checker.sv
bench/lfu_cache_table_tb.sv
